// ===== src/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types, codes and lookup function of the terminal key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

  // Longest CSI body that is ever matched, and how many of its bytes are kept
  // (the last one is always the incoming byte).
  localparam int unsigned CsiMaxLen = 4;
  localparam int unsigned SeqKeep   = CsiMaxLen - 1;

  localparam int unsigned MaxCsiBytes = 6;

  localparam logic [7:0] ByteEsc     = 8'h1B;
  localparam logic [7:0] ByteBracket = 8'h5B;
  localparam logic [7:0] ByteBlank   = 8'h20;
  localparam logic [7:0] ByteDel     = 8'h7F;

  typedef enum logic [4:0] {
    ActBackspace = 5'd0,
    ActReturn    = 5'd1,
    ActEol       = 5'd2,
    ActBol       = 5'd3,
    ActHistUp    = 5'd4,
    ActHistDown  = 5'd5,
    ActLeft      = 5'd6,
    ActRight     = 5'd7,
    ActIns       = 5'd8,
    ActDel       = 5'd9,
    ActComplete  = 5'd10,
    ActClrLine   = 5'd11,
    ActClrEol    = 5'd12,
    ActAddChar   = 5'd13,
    ActBot       = 5'd14,
    ActEot       = 5'd15,
    ActCancel    = 5'd16,
    ActExit      = 5'd17,
    ActNone      = 5'd18
  } action_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhEsc  = 3'b010,
    PhCsi  = 3'b100
  } phase_e;

  // One result word from the decoder to the output register.
  typedef struct packed {
    logic       valid;
    action_e    action;
    logic [7:0] key_char;
  } result_t;

  // Control bytes 0x00..0x1F and DEL; anything else unmapped.
  function automatic action_e ctrl_action(input logic [7:0] b);
    action_e a;
    unique case (b)
      8'h01:   a = ActBol;
      8'h02:   a = ActLeft;
      8'h03:   a = ActCancel;
      8'h04:   a = ActExit;
      8'h05:   a = ActEol;
      8'h06:   a = ActRight;
      8'h08:   a = ActBackspace;
      8'h09:   a = ActComplete;
      8'h0A:   a = ActReturn;
      8'h0B:   a = ActClrEol;
      8'h0D:   a = ActReturn;
      8'h0E:   a = ActHistDown;
      8'h10:   a = ActHistUp;
      8'h15:   a = ActClrLine;
      ByteDel: a = ActBackspace;
      default: a = ActNone;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== src/terminal_key_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_key_decoder_unit
// Terminal byte stream to line-editing key actions.
// ----------------------------------------------------------------------------
// Takes one terminal byte per word and gives at most one key action word per
// byte. Printable bytes give add_char, control bytes and DEL go through a
// fixed table, a byte after ESC other than [ or ESC gives add_char, and ESC [
// sequences are matched after every byte against the known cursor and editing
// keys; a sequence that has not matched after MaxCsiBytes body bytes gives
// "none". A byte is taken every cycle while the output is drained. An accepted
// byte sits in the byte register and is decoded there; its result goes to the
// result register when the byte advances, which waits while an older result
// is not taken. The byte register and the result register each hold one word:
// while a result waits, one more byte is taken, and then the input stalls until
// the result is taken, whether or not that byte gives a result.
`default_nettype none

module terminal_key_decoder_unit #(
  parameter int unsigned MaxCsiBytes = tkd_pkg::MaxCsiBytes
) (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output logic           in_ready_o,
  input  var logic [7:0] in_byte_i,
  output logic           out_valid_o,
  input  var logic       out_ready_i,
  output logic [4:0]     action_o,
  output logic [7:0]     key_char_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             advance;
  logic             out_valid_q;
  tkd_pkg::action_e action_q;
  logic [7:0]       key_char_q;
  tkd_pkg::result_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  tkd_decoder #(
    .MaxCsiBytes (MaxCsiBytes)
  ) u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      action_q   <= res.action;
      key_char_q <= res.key_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign key_char_o  = key_char_q;

endmodule

`default_nettype wire

// ===== src/tkd_csi_match.sv =====
// ----------------------------------------------------------------------------
// tkd_csi_match
// Exact compare of the collected CSI body against the fixed key sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_csi_match #(
  parameter int unsigned CntW = 3
) (
  input  var logic [CntW-1:0] len_i,   // body length including the new byte
  input  var logic [7:0]      body_i [tkd_pkg::CsiMaxLen],
  output tkd_pkg::action_e    action_o  // ActNone when nothing matches
);

  always_comb begin
    action_o = tkd_pkg::ActNone;
    if (len_i == CntW'(1)) begin
      case (body_i[0])
        8'h41:   action_o = tkd_pkg::ActHistUp;    // A
        8'h42:   action_o = tkd_pkg::ActHistDown;  // B
        8'h43:   action_o = tkd_pkg::ActRight;     // C
        8'h44:   action_o = tkd_pkg::ActLeft;      // D
        8'h46:   action_o = tkd_pkg::ActEol;       // F
        8'h48:   action_o = tkd_pkg::ActBol;       // H
        default: action_o = tkd_pkg::ActNone;
      endcase
    end else if (len_i == CntW'(2) && body_i[1] == 8'h7E) begin
      case (body_i[0])
        8'h31:   action_o = tkd_pkg::ActBol;
        8'h32:   action_o = tkd_pkg::ActIns;
        8'h33:   action_o = tkd_pkg::ActDel;
        8'h34:   action_o = tkd_pkg::ActEol;
        8'h37:   action_o = tkd_pkg::ActBol;
        8'h38:   action_o = tkd_pkg::ActEol;
        default: action_o = tkd_pkg::ActNone;
      endcase
    end else if (len_i == CntW'(4) && body_i[0] == 8'h31 && body_i[1] == 8'h3B &&
                 body_i[2] == 8'h35) begin
      // ESC [ 1 ; 5 D / C: ctrl-left / ctrl-right
      case (body_i[3])
        8'h44:   action_o = tkd_pkg::ActBot;
        8'h43:   action_o = tkd_pkg::ActEot;
        default: action_o = tkd_pkg::ActNone;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/tkd_decoder.sv =====
// ----------------------------------------------------------------------------
// tkd_decoder
// Escape state machine: phase, CSI byte count and collected body bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_decoder #(
  parameter int unsigned MaxCsiBytes = tkd_pkg::MaxCsiBytes
) (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             step_i,   // consume byte_i this cycle
  input  var logic [7:0]       byte_i,
  output tkd_pkg::result_t     res_o
);

  localparam int unsigned CntW = $clog2(MaxCsiBytes + 1);

  tkd_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      seq_q [tkd_pkg::SeqKeep];
  logic [7:0]      body  [tkd_pkg::CsiMaxLen];
  tkd_pkg::action_e csi_act;

  assign cnt_inc = cnt_q + CntW'(1);

  // Current body: stored bytes, with the incoming byte at the count position.
  always_comb begin
    for (int i = 0; i < int'(tkd_pkg::CsiMaxLen); i++) begin
      if (i < int'(tkd_pkg::SeqKeep) && cnt_q != CntW'(i)) begin
        body[i] = seq_q[i];
      end else begin
        body[i] = byte_i;
      end
    end
  end

  tkd_csi_match #(
    .CntW (CntW)
  ) u_match (
    .len_i    (cnt_inc),
    .body_i   (body),
    .action_o (csi_act)
  );

  always_comb begin
    phase_d        = phase_q;
    cnt_d          = cnt_q;
    res_o.valid    = 1'b0;
    res_o.action   = tkd_pkg::ActNone;
    res_o.key_char = tkd_pkg::ByteBlank;
    unique case (phase_q)
      tkd_pkg::PhEsc: begin
        if (byte_i == tkd_pkg::ByteBracket) begin
          phase_d = tkd_pkg::PhCsi;
          cnt_d   = '0;
        end else if (byte_i != tkd_pkg::ByteEsc) begin
          phase_d        = tkd_pkg::PhIdle;
          res_o.valid    = 1'b1;
          res_o.action   = tkd_pkg::ActAddChar;
          res_o.key_char = byte_i;
        end
      end
      tkd_pkg::PhCsi: begin
        cnt_d = cnt_inc;
        if (csi_act != tkd_pkg::ActNone) begin
          phase_d      = tkd_pkg::PhIdle;
          cnt_d        = '0;
          res_o.valid  = 1'b1;
          res_o.action = csi_act;
        end else if (cnt_inc >= CntW'(MaxCsiBytes)) begin
          phase_d     = tkd_pkg::PhIdle;
          cnt_d       = '0;
          res_o.valid = 1'b1;
        end
      end
      default: begin
        phase_d = tkd_pkg::PhIdle;
        if (byte_i >= 8'h20 && byte_i <= 8'h7E) begin
          res_o.valid    = 1'b1;
          res_o.action   = tkd_pkg::ActAddChar;
          res_o.key_char = byte_i;
        end else if (byte_i == tkd_pkg::ByteEsc) begin
          phase_d = tkd_pkg::PhEsc;
        end else begin
          res_o.valid  = 1'b1;
          res_o.action = tkd_pkg::ctrl_action(byte_i);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tkd_pkg::PhIdle;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Only the first bytes of a body are ever compared.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(tkd_pkg::SeqKeep); i++) begin
      if (step_i && phase_q == tkd_pkg::PhCsi && cnt_q == CntW'(i)) begin
        seq_q[i] <= byte_i;
      end
    end
  end

endmodule

`default_nettype wire
